/* hw/rtl/rtba_pkg.sv */
// rtba_pkg: shared codes, constants and structs of the region table allocator
// used by rtba_cell and region_table_bump_allocator_core; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rtba_pkg;

    // command codes
    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_CHECK   = 2'd2;
    localparam logic [1:0] CMD_CLEAR   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOSPACE  = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    // configuration register indexes
    localparam logic REG_POOL_BASE  = 1'b0;
    localparam logic REG_POOL_BYTES = 1'b1;

    // size of the descriptor region built by clear
    localparam logic [31:0] DESC_BYTES = 32'd4096;

    // token that walks the cell row, one cell per cycle
    typedef struct packed {
        logic        tok;       // token present
        logic        found;     // release match seen in an earlier cell
        logic        hit;       // check address inside an earlier region
        logic [31:0] end_val;   // end of the last valid region so far
        logic [31:0] fstart;    // start of the matched region
        logic [31:0] flen;      // length of the matched region
    } wave_t;

    // command context seen by every cell
    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] opnd;
        logic [31:0] pool_base;
        logic        clear;     // rebuild entry zero this cycle
    } bcast_t;

endpackage

`default_nettype wire

/* hw/rtl/region_table_bump_allocator_core.sv */
// region_table_bump_allocator_core: top level, command control and row of table cells
// depends on rtba_pkg and rtba_cell
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake          payload
// cfg       in         cfg_we             cfg_index, cfg_wdata
// in        in         in_valid/in_stall  cmd, operand
// out       out        out_valid/out_stall status, region_start, region_bytes, inside_res
//
// allocate with an immediate answer (zero size, full, no room) and clear go from transfer
// straight to the result state; every other command first waits for the token to walk
// the cell row one entry per cycle and leave its last cell.
// one command is in work at a time; a finished result waits in the result registers until the output register is free.
// reset empties the table (count and usage zero) and sets the pool registers.

module region_table_bump_allocator_core #(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire         cfg_index,
    input  wire  [31:0] cfg_wdata,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [1:0]  cmd,
    input  wire  [31:0] operand,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [1:0]  status,
    output logic [31:0] region_start,
    output logic [31:0] region_bytes,
    output logic        inside_res
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_C = CNT_W'(TABLE_ENTRIES);
    localparam logic [CNT_W-1:0] ONE_C  = CNT_W'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WAVE,
        S_DONE
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] pool_base_reg, pool_base_next;
    logic [31:0] pool_bytes_reg, pool_bytes_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0] bytes_reg, bytes_next;
    logic [1:0]  cmd_reg, cmd_next;
    logic [31:0] opnd_reg, opnd_next;
    logic        tok0_reg, tok0_next;
    logic [1:0]  res_status_reg, res_status_next;
    logic [31:0] res_start_reg, res_start_next;
    logic [31:0] res_bytes_reg, res_bytes_next;
    logic        res_inside_reg, res_inside_next;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  status_reg, status_next;
    logic [31:0] region_start_reg, region_start_next;
    logic [31:0] region_bytes_reg, region_bytes_next;
    logic        inside_reg, inside_next;

    logic             accept;
    logic             no_room;
    rtba_pkg::bcast_t bc;
    rtba_pkg::wave_t  chain [TABLE_ENTRIES+1];
    logic [31:0]      start_q [TABLE_ENTRIES];
    logic [31:0]      len_q [TABLE_ENTRIES];
    rtba_pkg::wave_t  wave_end;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);
    assign no_room  = ({1'b0, bytes_reg} + {1'b0, operand}) > {1'b0, pool_bytes_reg};

    // command context for the cells
    always_comb
    begin
        bc.cmd       = cmd_reg;
        bc.opnd      = opnd_reg;
        bc.pool_base = pool_base_reg;
        bc.clear     = accept && (cmd == rtba_pkg::CMD_CLEAR);
    end

    // token entering the first cell
    always_comb
    begin
        chain[0]         = '0;
        chain[0].tok     = tok0_reg;
        chain[0].end_val = pool_base_reg;
    end

    // row of table cells
    for (genvar gi = 0; gi < TABLE_ENTRIES; gi++)
    begin : g_cell
        logic [31:0] nb_start;
        logic [31:0] nb_len;
        if (gi == TABLE_ENTRIES - 1)
        begin : g_last
            assign nb_start = '0;
            assign nb_len   = '0;
        end
        else
        begin : g_mid
            assign nb_start = start_q[gi+1];
            assign nb_len   = len_q[gi+1];
        end
        rtba_cell #(
            .IDX   (gi),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .bc       (bc),
            .count    (count_reg),
            .wave_in  (chain[gi]),
            .nb_start (nb_start),
            .nb_len   (nb_len),
            .wave_out (chain[gi+1]),
            .start_q  (start_q[gi]),
            .len_q    (len_q[gi])
        );
    end

    assign wave_end = chain[TABLE_ENTRIES];

    // control sequencing and result collection
    always_comb
    begin
        state_next        = state_reg;
        pool_base_next    = pool_base_reg;
        pool_bytes_next   = pool_bytes_reg;
        count_next        = count_reg;
        bytes_next        = bytes_reg;
        cmd_next          = cmd_reg;
        opnd_next         = opnd_reg;
        tok0_next         = 1'b0;
        res_status_next   = res_status_reg;
        res_start_next    = res_start_reg;
        res_bytes_next    = res_bytes_reg;
        res_inside_next   = res_inside_reg;
        out_valid_next    = out_valid_reg;
        status_next       = status_reg;
        region_start_next = region_start_reg;
        region_bytes_next = region_bytes_reg;
        inside_next       = inside_reg;

        // configuration writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                rtba_pkg::REG_POOL_BASE:  pool_base_next  = cfg_wdata;
                rtba_pkg::REG_POOL_BYTES: pool_bytes_next = cfg_wdata;
                default:                  pool_base_next  = pool_base_reg;
            endcase
        end

        // output transfer
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next        = cmd;
                    opnd_next       = operand;
                    res_status_next = rtba_pkg::ST_OK;
                    res_start_next  = '0;
                    res_bytes_next  = '0;
                    res_inside_next = 1'b0;
                    state_next      = S_DONE;
                    unique case (cmd) inside
                        rtba_pkg::CMD_ALLOC:
                        begin
                            if (operand == '0)
                            begin
                                res_status_next = rtba_pkg::ST_OK;
                            end
                            else if (count_reg >= FULL_C)
                            begin
                                res_status_next = rtba_pkg::ST_FULL;
                            end
                            else if (no_room)
                            begin
                                res_status_next = rtba_pkg::ST_NOSPACE;
                            end
                            else
                            begin
                                tok0_next  = 1'b1;
                                state_next = S_WAVE;
                            end
                        end
                        rtba_pkg::CMD_RELEASE, rtba_pkg::CMD_CHECK:
                        begin
                            tok0_next  = 1'b1;
                            state_next = S_WAVE;
                        end
                        default:
                        begin
                            count_next = ONE_C;
                            bytes_next = rtba_pkg::DESC_BYTES;
                        end
                    endcase
                end
            end
            S_WAVE:
            begin
                if (wave_end.tok)
                begin
                    state_next = S_DONE;
                    case (cmd_reg)
                        rtba_pkg::CMD_ALLOC:
                        begin
                            res_start_next = wave_end.end_val;
                            count_next     = count_reg + ONE_C;
                            bytes_next     = bytes_reg + opnd_reg;
                        end
                        rtba_pkg::CMD_RELEASE:
                        begin
                            if (wave_end.found)
                            begin
                                res_start_next = wave_end.fstart;
                                res_bytes_next = wave_end.flen;
                                bytes_next     = (bytes_reg >= wave_end.flen) ?
                                                 bytes_reg - wave_end.flen : '0;
                                count_next     = count_reg - ONE_C;
                            end
                            else
                            begin
                                res_status_next = rtba_pkg::ST_NOTFOUND;
                            end
                        end
                        rtba_pkg::CMD_CHECK:
                        begin
                            res_inside_next = wave_end.hit;
                        end
                        default:
                        begin
                            res_status_next = res_status_reg;
                        end
                    endcase
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    status_next       = res_status_reg;
                    region_start_next = res_start_reg;
                    region_bytes_next = res_bytes_reg;
                    inside_next       = res_inside_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            pool_base_reg    <= '0;
            pool_bytes_reg   <= 32'd4194304;
            count_reg        <= '0;
            bytes_reg        <= '0;
            cmd_reg          <= rtba_pkg::CMD_ALLOC;
            opnd_reg         <= '0;
            tok0_reg         <= 1'b0;
            res_status_reg   <= rtba_pkg::ST_OK;
            res_start_reg    <= '0;
            res_bytes_reg    <= '0;
            res_inside_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            status_reg       <= rtba_pkg::ST_OK;
            region_start_reg <= '0;
            region_bytes_reg <= '0;
            inside_reg       <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            pool_base_reg    <= pool_base_next;
            pool_bytes_reg   <= pool_bytes_next;
            count_reg        <= count_next;
            bytes_reg        <= bytes_next;
            cmd_reg          <= cmd_next;
            opnd_reg         <= opnd_next;
            tok0_reg         <= tok0_next;
            res_status_reg   <= res_status_next;
            res_start_reg    <= res_start_next;
            res_bytes_reg    <= res_bytes_next;
            res_inside_reg   <= res_inside_next;
            out_valid_reg    <= out_valid_next;
            status_reg       <= status_next;
            region_start_reg <= region_start_next;
            region_bytes_reg <= region_bytes_next;
            inside_reg       <= inside_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign region_start = region_start_reg;
    assign region_bytes = region_bytes_reg;
    assign inside_res   = inside_reg;

endmodule

`default_nettype wire

/* hw/rtl/rtba_cell.sv */
// rtba_cell: one table entry (start, length) plus its stage of the token chain
// depends on rtba_pkg
`timescale 1ns / 1ps
`default_nettype none

module rtba_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire rtba_pkg::bcast_t  bc,
    input  wire logic [CNT_W-1:0]  count,
    input  wire rtba_pkg::wave_t   wave_in,
    input  wire logic [31:0]       nb_start,
    input  wire logic [31:0]       nb_len,
    output rtba_pkg::wave_t        wave_out,
    output logic [31:0]            start_q,
    output logic [31:0]            len_q
);

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    logic [31:0]     start_reg, start_next;
    logic [31:0]     len_reg, len_next;
    rtba_pkg::wave_t wave_reg, wave_next;

    logic        valid;
    logic        match;
    logic        shift_in;
    logic [31:0] end_sum;
    logic [32:0] hi_sum;
    logic        in_range;

    // local compares on this entry
    assign valid    = IDX_C < count;
    assign end_sum  = start_reg + len_reg;
    assign hi_sum   = {1'b0, start_reg} + {1'b0, len_reg};
    assign in_range = (bc.opnd >= start_reg) && ({1'b0, bc.opnd} < hi_sum);
    assign match    = valid && (start_reg == bc.opnd) && !wave_in.found;
    assign shift_in = wave_in.found || match;

    // token update passed on to the next cell
    always_comb
    begin
        wave_next = wave_in;
        if (wave_in.tok)
        begin
            case (bc.cmd)
                rtba_pkg::CMD_ALLOC:
                begin
                    if (valid)
                    begin
                        wave_next.end_val = end_sum;
                    end
                end
                rtba_pkg::CMD_RELEASE:
                begin
                    if (match)
                    begin
                        wave_next.found  = 1'b1;
                        wave_next.fstart = start_reg;
                        wave_next.flen   = len_reg;
                    end
                end
                rtba_pkg::CMD_CHECK:
                begin
                    if (valid && in_range)
                    begin
                        wave_next.hit = 1'b1;
                    end
                end
                default:
                begin
                    wave_next = wave_in;
                end
            endcase
        end
    end

    // entry update: clear, append, or take the neighbor's entry on compaction
    always_comb
    begin
        start_next = start_reg;
        len_next   = len_reg;
        if (bc.clear && (IDX == 0))
        begin
            start_next = bc.pool_base;
            len_next   = rtba_pkg::DESC_BYTES;
        end
        else if (wave_in.tok)
        begin
            if ((bc.cmd == rtba_pkg::CMD_ALLOC) && (IDX_C == count))
            begin
                start_next = wave_in.end_val;
                len_next   = bc.opnd;
            end
            else if ((bc.cmd == rtba_pkg::CMD_RELEASE) && shift_in)
            begin
                start_next = nb_start;
                len_next   = nb_len;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        len_reg   <= len_next;
    end

    // token stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_reg <= '0;
        end
        else
        begin
            wave_reg <= wave_next;
        end
    end

    assign wave_out = wave_reg;
    assign start_q  = start_reg;
    assign len_q    = len_reg;

endmodule

`default_nettype wire

/* bench/region_table_bump_allocator_core_tb.sv */
// region_table_bump_allocator_core_tb: self-checking bench for the region table allocator,
// with a clocked driver and monitor, a shadow table predictor, random input gaps and random output stall
// depends on rtba_pkg and region_table_bump_allocator_core
`timescale 1ns / 1ps

module region_table_bump_allocator_core_tb;

    localparam int TABLE_ENTRIES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int QUIET_FROM    = 4000;
    localparam int QUIET_TO      = 8000;
    localparam int RANDOM_ITEMS  = 150;

    // how a queued command gets its operand when it is driven
    typedef enum int {AIM_RAW, AIM_START, AIM_INNER, AIM_END, AIM_BELOW} aim_t;

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] opnd;
        aim_t        aim;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] rstart;
        logic [31:0] rbytes;
        logic        in_region;
    } answer_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd       = '0;
    logic [31:0] operand   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [31:0] region_start;
    logic [31:0] region_bytes;
    logic        inside_res;

    // shadow copy of the region table and pool registers
    logic [31:0] tbl_start [TABLE_ENTRIES];
    logic [31:0] tbl_len [TABLE_ENTRIES];
    int          region_cnt = 0;
    logic [31:0] used_bytes = '0;
    logic [31:0] base_reg   = '0;
    logic [31:0] limit_reg  = 32'd4194304;

    cmd_item_t   cmd_backlog[$];
    answer_t     pending_answers[$];
    int          n_queued   = 0;
    int          n_taken    = 0;
    int          fail_count = 0;
    int          cyc        = 0;
    logic        in_xfer    = 1'b0;

    region_table_bump_allocator_core #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .operand(operand),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .region_start(region_start),
        .region_bytes(region_bytes),
        .inside_res(inside_res)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // table update and answer for one command
    task automatic model_region_op(input logic [1:0] c, input logic [31:0] op,
                                   output answer_t ans);
        int          i;
        int          hit_idx;
        logic [31:0] addr;
        logic [32:0] span_end;
        ans = '0;
        case (c)
            rtba_pkg::CMD_ALLOC:
            begin
                // zero size leaves everything as is
                if (op != '0)
                begin
                    if (region_cnt >= TABLE_ENTRIES)
                        ans.status = rtba_pkg::ST_FULL;
                    else if ({1'b0, used_bytes} + {1'b0, op} > {1'b0, limit_reg})
                        ans.status = rtba_pkg::ST_NOSPACE;
                    else
                    begin
                        if (region_cnt == 0)
                            addr = base_reg;
                        else
                            addr = tbl_start[region_cnt - 1] + tbl_len[region_cnt - 1];
                        tbl_start[region_cnt] = addr;
                        tbl_len[region_cnt] = op;
                        region_cnt++;
                        used_bytes += op;
                        ans.rstart = addr;
                    end
                end
            end
            rtba_pkg::CMD_RELEASE:
            begin
                hit_idx = -1;
                for (i = 0; i < region_cnt; i++)
                    if (hit_idx < 0 && tbl_start[i] == op)
                        hit_idx = i;
                if (hit_idx < 0)
                    ans.status = rtba_pkg::ST_NOTFOUND;
                else
                begin
                    ans.rstart = tbl_start[hit_idx];
                    ans.rbytes = tbl_len[hit_idx];
                    used_bytes = (used_bytes >= ans.rbytes) ? used_bytes - ans.rbytes : '0;
                    // close the gap
                    for (i = hit_idx; i + 1 < region_cnt; i++)
                    begin
                        tbl_start[i] = tbl_start[i + 1];
                        tbl_len[i] = tbl_len[i + 1];
                    end
                    region_cnt--;
                end
            end
            rtba_pkg::CMD_CHECK:
            begin
                // region end computed without wrap, upper bound exclusive
                for (i = 0; i < region_cnt; i++)
                begin
                    span_end = {1'b0, tbl_start[i]} + {1'b0, tbl_len[i]};
                    if ({1'b0, op} >= {1'b0, tbl_start[i]} && {1'b0, op} < span_end)
                        ans.in_region = 1'b1;
                end
            end
            default:
            begin
                tbl_start[0] = base_reg;
                tbl_len[0] = rtba_pkg::DESC_BYTES;
                region_cnt = 1;
                used_bytes = rtba_pkg::DESC_BYTES;
            end
        endcase
    endtask

    // operand aimed at or next to a live region, taken from the table as it stands now, or the queued raw operand
    function automatic logic [31:0] aimed_operand(cmd_item_t it);
        int          k;
        logic [31:0] s;
        logic [31:0] l;
        if (it.aim == AIM_RAW || region_cnt == 0)
            return it.opnd;
        k = $urandom_range(region_cnt - 1);
        s = tbl_start[k];
        l = tbl_len[k];
        case (it.aim)
            AIM_START: return s;
            AIM_INNER: return s + $urandom_range(l - 1);
            AIM_END:   return s + l;
            default:   return s - 1;
        endcase
    endfunction

    // random idle decision, switched off inside the quiet window
    function automatic bit gap_now();
        if (cyc >= QUIET_FROM && cyc < QUIET_TO)
            return 1'b0;
        return $urandom_range(99) < 21;
    endfunction

    function automatic cmd_item_t random_item();
        cmd_item_t it;
        int        pick;
        pick = $urandom_range(99);
        it.opnd = $urandom;
        it.aim = AIM_RAW;
        if (pick < 40)
        begin
            it.cmd = rtba_pkg::CMD_ALLOC;
            pick = $urandom_range(19);
            if (pick == 0)
                it.opnd = '0;
            else if (pick == 1)
                it.opnd = 32'hFFFF_FFFF;
            else if (pick > 3)
                it.opnd = $urandom_range(32'h4000, 1);
        end
        else if (pick < 65)
        begin
            it.cmd = rtba_pkg::CMD_RELEASE;
            pick = $urandom_range(9);
            if (pick < 7)
                it.aim = AIM_START;
            else if (pick == 7)
                it.aim = AIM_INNER;
            else if (pick == 8)
                it.aim = AIM_BELOW;
        end
        else if (pick < 92)
        begin
            it.cmd = rtba_pkg::CMD_CHECK;
            it.aim = aim_t'($urandom_range(4));
        end
        else
            it.cmd = rtba_pkg::CMD_CLEAR;
        return it;
    endfunction

    task automatic queue_cmd(input logic [1:0] c, input logic [31:0] op, input aim_t a);
        cmd_item_t it;
        it = '{c, op, a};
        cmd_backlog.push_back(it);
        n_queued++;
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // register write, only while the block is idle
    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == rtba_pkg::REG_POOL_BASE)
            base_reg = val;
        else
            limit_reg = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (n_taken != n_queued || pending_answers.size() != 0);
        repeat (TABLE_ENTRIES + 4) @(negedge clk);
    endtask

    task automatic run_phase(input int n, input logic [31:0] pbase, input logic [31:0] pbytes);
        cmd_item_t it;
        write_reg(rtba_pkg::REG_POOL_BASE, pbase);
        write_reg(rtba_pkg::REG_POOL_BYTES, pbytes);
        repeat (n)
        begin
            it = random_item();
            queue_cmd(it.cmd, it.opnd, it.aim);
        end
        wait_drained();
    endtask

    // command driver and output stall, changed at the falling edge
    always @(negedge clk)
    begin : drive
        cmd_item_t nxt;
        out_stall <= gap_now();
        if (!in_valid || in_xfer)
        begin
            if (rst_n && cmd_backlog.size() > 0 && !gap_now())
            begin
                nxt = cmd_backlog.pop_front();
                in_valid <= 1'b1;
                cmd <= nxt.cmd;
                operand <= aimed_operand(nxt);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result check and prediction of each accepted transfer
    always @(posedge clk)
    begin : observe
        answer_t got;
        answer_t want;
        in_xfer = rst_n && in_valid && in_stall === 1'b0;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            got = {status, region_start, region_bytes, inside_res};
            if (pending_answers.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                fail_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                report_field("status", 32'(want.status), 32'(got.status));
                report_field("region_start", want.rstart, got.rstart);
                report_field("region_bytes", want.rbytes, got.rbytes);
                report_field("inside_res", 32'(want.in_region), 32'(got.in_region));
            end
        end
        if (in_xfer)
        begin
            model_region_op(cmd, operand, want);
            pending_answers.push_back(want);
            n_taken++;
        end
    end

    // cycle count and timeout
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // stimulus
    initial
    begin : stimulus
        int i;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // empty table after reset
        queue_cmd(rtba_pkg::CMD_CHECK, 32'h0, AIM_RAW);
        queue_cmd(rtba_pkg::CMD_RELEASE, 32'h0, AIM_RAW);
        queue_cmd(rtba_pkg::CMD_ALLOC, 32'h0, AIM_RAW);
        queue_cmd(rtba_pkg::CMD_ALLOC, 32'h100, AIM_RAW);
        queue_cmd(rtba_pkg::CMD_CHECK, 32'hFF, AIM_RAW);
        queue_cmd(rtba_pkg::CMD_CHECK, 32'h100, AIM_RAW);
        // descriptor region, exact fit and no room
        queue_cmd(rtba_pkg::CMD_CLEAR, 32'hFFFF_FFFF, AIM_RAW);
        queue_cmd(rtba_pkg::CMD_ALLOC, 32'hFFFF_FFFF, AIM_RAW);
        queue_cmd(rtba_pkg::CMD_ALLOC, 32'h003F_F000, AIM_RAW);
        queue_cmd(rtba_pkg::CMD_ALLOC, 32'h1, AIM_RAW);
        queue_cmd(rtba_pkg::CMD_RELEASE, 32'h1000, AIM_RAW);
        queue_cmd(rtba_pkg::CMD_RELEASE, 32'h1000, AIM_RAW);
        // fill the table, then one past full and a zero size while full
        for (i = 0; i < TABLE_ENTRIES; i++)
            queue_cmd(rtba_pkg::CMD_ALLOC, 32'h10, AIM_RAW);
        queue_cmd(rtba_pkg::CMD_ALLOC, 32'h0, AIM_RAW);
        queue_cmd(rtba_pkg::CMD_RELEASE, 32'h0, AIM_START);
        queue_cmd(rtba_pkg::CMD_CHECK, 32'h0, AIM_INNER);
        queue_cmd(rtba_pkg::CMD_CHECK, 32'h0, AIM_END);
        wait_drained();

        // random phases over several pool settings, extremes included
        run_phase(RANDOM_ITEMS, $urandom, 32'hFFFF_FFFF);
        run_phase(RANDOM_ITEMS, 32'hFFFF_F000, 32'h0010_0000);
        run_phase(50, 32'h0, 32'h0);
        run_phase(RANDOM_ITEMS, $urandom, 32'h0001_0000);
        run_phase(RANDOM_ITEMS, 32'hFFFF_FFFF, 32'd4194304);
        run_phase(100, $urandom, $urandom);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
